// ----- rtl/core/ttrrq_pkg.sv -----
// ----------------------------------------------------------------------------
// ttrrq_pkg
// shared opcodes, status codes and the controller/datapath interface types
// ----------------------------------------------------------------------------
package ttrrq_pkg;

  localparam int OP_W = 4;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 4'd0,
    OP_FIND    = 4'd1,
    OP_ACQUIRE = 4'd2,
    OP_RELEASE = 4'd3,
    OP_REMOVE  = 4'd4,
    OP_ENQUEUE = 4'd5,
    OP_UNQUEUE = 4'd6,
    OP_DEQUEUE = 4'd7,
    OP_ROTATE  = 4'd8,
    OP_PICK    = 4'd9
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_IDS    = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_BAD_STATE = 3'd5
  } status_t;

  // datapath micro operations
  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_ACCEPT,
    UOP_LK_INIT,
    UOP_LK_STEP,
    UOP_FF_INIT,
    UOP_FF_STEP,
    UOP_CREATE,
    UOP_RD_S,
    UOP_RD_U,
    UOP_ACQ_S,
    UOP_REL_S,
    UOP_ABANDON_S,
    UOP_INVALIDATE_S,
    UOP_U_FROM_S,
    UOP_U_FROM_TAIL,
    UOP_UNLINK_U,
    UOP_PUSH1_U,
    UOP_PUSH2_U,
    UOP_RES_ID,
    UOP_RES_TID,
    UOP_PICK_U,
    UOP_FINISH
  } uop_t;

  typedef struct packed {
    uop_t    uop;
    logic    st_en;
    status_t st;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    rel;
    logic    lk_hit;
    logic    lk_miss;
    logic    ff_hit;
    logic    ff_end;
    logic    ids_out;
    logic    q_empty;
    logic    inq_s;
    logic    cur_alone;
    logic    ref_zero;
    logic    free_cond;
    logic    u_is_s;
    logic    out_busy;
  } sts_t;

endpackage

// ----- rtl/core/thread_table_round_robin_queue_unit.sv -----
// ----------------------------------------------------------------------------
// thread_table_round_robin_queue_unit
// thread table with reference counts and a round-robin run queue
// ----------------------------------------------------------------------------
// usage:
//   command channel (in_valid/in_ready) carries opcode, thread_id and
//   release_former; one transaction per command. result channel
//   (out_valid/out_ready) returns exactly one transaction per command:
//   status, result_id, found, freed and the run queue length after it.
//   commands are processed one at a time. id lookup and free slot search
//   walk the table one slot per cycle through the slot memory read port,
//   so the result of a command that addresses a thread or creates one is
//   valid once that search is done and after any unlinks, inserts and
//   rotations (two at most for pick_next), the read of the picked thread
//   and a release that may free a queued slot; dequeue and rotate skip the
//   search and start from the queue tail, and on an empty queue report ST_EMPTY.
//   the result sits in an output register: a new command is accepted while
//   the previous result waits, and the unit only holds at the end of the
//   next command until out_ready drains the register.
//   reset clears the slot valid and queued flags, empties the queue and
//   sets the next id to 1; slot contents are rewritten before they are read.
// ----------------------------------------------------------------------------
module thread_table_round_robin_queue_unit #(
  parameter int MAX_THREADS = 64,
  parameter int ID_BITS     = 16,
  parameter int REF_BITS    = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ttrrq_pkg::OP_W-1:0]       opcode,
  input  logic [ID_BITS-1:0]               thread_id,
  input  logic                             release_former,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ttrrq_pkg::status_t               status,
  output logic [ID_BITS-1:0]               result_id,
  output logic                             found,
  output logic                             freed,
  output logic [$clog2(MAX_THREADS+1)-1:0] queue_count
);
  import ttrrq_pkg::*;

  // micro operation command and datapath flags
  cmd_t cmd;
  sts_t sts;

  // sequencer: one state per step of a command
  ttrrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot memories, queue pointers and result register
  ttrrq_dp #(
    .MAX_THREADS (MAX_THREADS),
    .ID_BITS     (ID_BITS),
    .REF_BITS    (REF_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .opcode         (opcode),
    .thread_id      (thread_id),
    .release_former (release_former),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .result_id      (result_id),
    .found          (found),
    .freed          (freed),
    .queue_count    (queue_count)
  );

endmodule

// ----- rtl/core/ttrrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttrrq_ctrl
// sequencer that walks each command through datapath micro operations
// ----------------------------------------------------------------------------
module ttrrq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ttrrq_pkg::sts_t sts,
  output ttrrq_pkg::cmd_t cmd
);
  import ttrrq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_FF, S_CREATE, S_LK, S_RDS, S_EXEC, S_REL, S_FREE,
    S_RDU, S_UNLINK, S_PUSH1, S_PUSH2, S_AFTER_ROT, S_RDID, S_RESID,
    S_RDPICK, S_PICK, S_RDCUR, S_DONE
  } state_t;

  state_t state, state_next;
  logic   rot_act, rot_act_next;
  logic   second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rot_act <= 1'b0;
      second  <= 1'b0;
    end else begin
      state   <= state_next;
      rot_act <= rot_act_next;
      second  <= second_next;
    end
  end

  always_comb begin
    state_next   = state;
    rot_act_next = rot_act;
    second_next  = second;
    cmd.uop      = UOP_NONE;
    cmd.st_en    = 1'b0;
    cmd.st       = ST_OK;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.uop      = UOP_ACCEPT;
          rot_act_next = 1'b0;
          second_next  = 1'b0;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op) inside
          OP_CREATE: begin
            if (sts.ids_out) begin
              cmd.st_en  = 1'b1;
              cmd.st     = ST_NO_IDS;
              state_next = S_DONE;
            end else begin
              cmd.uop    = UOP_FF_INIT;
              state_next = S_FF;
            end
          end
          OP_FIND, OP_ACQUIRE, OP_RELEASE, OP_REMOVE, OP_ENQUEUE, OP_UNQUEUE,
          OP_PICK: begin
            cmd.uop    = UOP_LK_INIT;
            state_next = S_LK;
          end
          OP_DEQUEUE, OP_ROTATE: begin
            if (sts.q_empty) begin
              cmd.st_en  = 1'b1;
              cmd.st     = ST_EMPTY;
              state_next = S_DONE;
            end else begin
              cmd.uop      = UOP_U_FROM_TAIL;
              rot_act_next = (sts.op == OP_ROTATE);
              state_next   = S_RDU;
            end
          end
          default: begin
            cmd.st_en  = 1'b1;
            cmd.st     = ST_BAD_STATE;
            state_next = S_DONE;
          end
        endcase
      end
      S_FF: begin
        cmd.uop = UOP_FF_STEP;
        if (sts.ff_hit) begin
          state_next = S_CREATE;
        end else if (sts.ff_end) begin
          cmd.st_en  = 1'b1;
          cmd.st     = ST_FULL;
          state_next = S_DONE;
        end
      end
      S_CREATE: begin
        cmd.uop    = UOP_CREATE;
        state_next = S_DONE;
      end
      S_LK: begin
        cmd.uop = UOP_LK_STEP;
        if (sts.lk_hit) begin
          state_next = S_RDS;
        end else if (sts.lk_miss) begin
          cmd.st_en  = 1'b1;
          cmd.st     = ST_NOT_FOUND;
          state_next = S_DONE;
        end
      end
      S_RDS: begin
        cmd.uop    = UOP_RD_S;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (sts.op)
          OP_ACQUIRE: cmd.uop = UOP_ACQ_S;
          OP_RELEASE: state_next = S_REL;
          OP_REMOVE: begin
            cmd.uop = UOP_ABANDON_S;
            if (sts.ref_zero) state_next = S_FREE;
          end
          OP_ENQUEUE: begin
            if (sts.inq_s) begin
              cmd.st_en = 1'b1;
              cmd.st    = ST_BAD_STATE;
            end else begin
              cmd.uop    = UOP_U_FROM_S;
              state_next = S_PUSH1;
            end
          end
          OP_UNQUEUE: begin
            if (!sts.inq_s) begin
              cmd.st_en = 1'b1;
              cmd.st    = ST_BAD_STATE;
            end else begin
              cmd.uop    = UOP_U_FROM_S;
              state_next = S_RDU;
            end
          end
          OP_PICK: begin
            if (sts.q_empty) begin
              cmd.uop   = UOP_RES_TID;
              cmd.st_en = 1'b1;
              cmd.st    = ST_EMPTY;
            end else if (sts.cur_alone) begin
              cmd.uop = UOP_RES_TID;
            end else begin
              cmd.uop      = UOP_U_FROM_TAIL;
              rot_act_next = 1'b1;
              state_next   = S_RDU;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_REL: begin
        if (sts.ref_zero) begin
          cmd.st_en  = 1'b1;
          cmd.st     = ST_BAD_STATE;
          state_next = S_DONE;
        end else begin
          cmd.uop    = UOP_REL_S;
          state_next = sts.free_cond ? S_FREE : S_DONE;
        end
      end
      S_FREE: begin
        cmd.uop      = UOP_INVALIDATE_S;
        rot_act_next = 1'b0;
        state_next   = sts.inq_s ? S_RDU : S_DONE;
      end
      S_RDU: begin
        cmd.uop    = UOP_RD_U;
        state_next = S_UNLINK;
      end
      S_UNLINK: begin
        cmd.uop = UOP_UNLINK_U;
        if (rot_act) state_next = S_PUSH1;
        else if (sts.op == OP_DEQUEUE) state_next = S_RDID;
        else state_next = S_DONE;
      end
      S_PUSH1: begin
        cmd.uop    = UOP_PUSH1_U;
        state_next = S_PUSH2;
      end
      S_PUSH2: begin
        cmd.uop    = UOP_PUSH2_U;
        state_next = rot_act ? S_AFTER_ROT : S_DONE;
      end
      S_AFTER_ROT: begin
        if (sts.op == OP_ROTATE) begin
          state_next = S_RDID;
        end else if (sts.u_is_s && !second) begin
          // rotated onto the current thread: go around once more
          cmd.uop     = UOP_U_FROM_TAIL;
          second_next = 1'b1;
          state_next  = S_RDU;
        end else begin
          state_next = S_RDPICK;
        end
      end
      S_RDID: begin
        cmd.uop    = UOP_RD_U;
        state_next = S_RESID;
      end
      S_RESID: begin
        cmd.uop    = UOP_RES_ID;
        state_next = S_DONE;
      end
      S_RDPICK: begin
        cmd.uop    = UOP_RD_U;
        state_next = S_PICK;
      end
      S_PICK: begin
        cmd.uop    = UOP_PICK_U;
        state_next = sts.rel ? S_RDCUR : S_DONE;
      end
      S_RDCUR: begin
        cmd.uop    = UOP_RD_S;
        state_next = S_REL;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.uop    = UOP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/ttrrq_dp.sv -----
// ----------------------------------------------------------------------------
// ttrrq_dp
// thread table memories, run queue pointers and the result register
// ----------------------------------------------------------------------------
module ttrrq_dp #(
  parameter int MAX_THREADS = 64,
  parameter int ID_BITS     = 16,
  parameter int REF_BITS    = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ttrrq_pkg::cmd_t                       cmd,
  output ttrrq_pkg::sts_t                       sts,
  input  logic [ttrrq_pkg::OP_W-1:0]            opcode,
  input  logic [ID_BITS-1:0]                    thread_id,
  input  logic                                  release_former,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output ttrrq_pkg::status_t                    status,
  output logic [ID_BITS-1:0]                    result_id,
  output logic                                  found,
  output logic                                  freed,
  output logic [$clog2(MAX_THREADS+1)-1:0]      queue_count
);
  import ttrrq_pkg::*;

  localparam int IDX_W  = $clog2(MAX_THREADS);
  localparam int SCAN_W = IDX_W + 1;
  localparam int CNT_W  = $clog2(MAX_THREADS + 1);
  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(MAX_THREADS);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  // slot memories
  logic [ID_BITS-1:0]  id_mem  [MAX_THREADS];
  logic [REF_BITS-1:0] ref_mem [MAX_THREADS];
  logic                ab_mem  [MAX_THREADS];
  logic [IDX_W-1:0]    nx_mem  [MAX_THREADS];
  logic [IDX_W-1:0]    pv_mem  [MAX_THREADS];

  logic [ID_BITS-1:0]  rd_id;
  logic [REF_BITS-1:0] rd_ref;
  logic                rd_ab;
  logic [IDX_W-1:0]    rd_nx, rd_pv;
  logic [IDX_W-1:0]    rd_addr;

  logic                id_we, ref_we, ab_we, nx_we, pv_we;
  logic [IDX_W-1:0]    id_wa, ref_wa, ab_wa, nx_wa, pv_wa;
  logic [ID_BITS-1:0]  id_wd;
  logic [REF_BITS-1:0] ref_wd;
  logic                ab_wd;
  logic [IDX_W-1:0]    nx_wd, pv_wd;

  // control state
  logic [MAX_THREADS-1:0] valid, inq;
  logic [IDX_W-1:0]       head, tail;
  logic [CNT_W-1:0]       qlen;
  logic [ID_BITS:0]       next_id;
  logic [SCAN_W-1:0]      scan;
  logic                   cmp_v;

  // working registers
  opcode_t             op_r;
  logic [ID_BITS-1:0]  tid_r;
  logic                rel_r;
  logic [IDX_W-1:0]    cmp_idx, s, u;
  status_t             w_status;
  logic [ID_BITS-1:0]  w_result;
  logic                w_found, w_freed;

  logic [IDX_W-1:0]    scan_idx;
  logic                lk_hit;
  logic [REF_BITS-1:0] ref_inc;

  assign scan_idx = scan[IDX_W-1:0];
  assign lk_hit   = cmp_v && valid[cmp_idx] && (rd_id == tid_r);
  assign ref_inc  = (rd_ref == REF_MAX) ? rd_ref : rd_ref + REF_BITS'(1);

  always_comb begin
    sts.op        = op_r;
    sts.rel       = rel_r;
    sts.lk_hit    = lk_hit;
    sts.lk_miss   = (scan == SCAN_END) && !cmp_v;
    sts.ff_hit    = (scan != SCAN_END) && !valid[scan_idx];
    sts.ff_end    = (scan == SCAN_END);
    sts.ids_out   = next_id[ID_BITS];
    sts.q_empty   = (qlen == '0);
    sts.inq_s     = inq[s];
    sts.cur_alone = inq[s] && (qlen == CNT_W'(1));
    sts.ref_zero  = (rd_ref == '0);
    sts.free_cond = (rd_ref == REF_BITS'(1)) && rd_ab;
    sts.u_is_s    = (u == s);
    sts.out_busy  = out_valid && !out_ready;
  end

  // read address and write ports
  always_comb begin
    rd_addr = s;
    id_we = 1'b0; ref_we = 1'b0; ab_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
    id_wa = s; ref_wa = s; ab_wa = s; nx_wa = u; pv_wa = u;
    id_wd  = next_id[ID_BITS-1:0];
    ref_wd = '0;
    ab_wd  = 1'b0;
    nx_wd  = u;
    pv_wd  = u;
    case (cmd.uop)
      UOP_LK_STEP: rd_addr = scan_idx;
      UOP_RD_U:    rd_addr = u;
      UOP_CREATE: begin
        id_we = 1'b1; ref_we = 1'b1; ab_we = 1'b1;
      end
      UOP_ACQ_S: begin
        ref_we = 1'b1;
        ref_wd = ref_inc;
      end
      UOP_REL_S: begin
        ref_we = 1'b1;
        ref_wd = rd_ref - REF_BITS'(1);
      end
      UOP_PICK_U: begin
        ref_we = 1'b1;
        ref_wa = u;
        ref_wd = ref_inc;
      end
      UOP_ABANDON_S: begin
        ab_we = 1'b1;
        ab_wd = 1'b1;
      end
      UOP_UNLINK_U: begin
        nx_we = (u != head);
        nx_wa = rd_pv;
        nx_wd = rd_nx;
        pv_we = (u != tail);
        pv_wa = rd_nx;
        pv_wd = rd_pv;
      end
      UOP_PUSH1_U: begin
        nx_we = 1'b1;
        nx_wd = (qlen == '0) ? u : head;
        pv_we = 1'b1;
      end
      UOP_PUSH2_U: begin
        pv_we = (qlen != '0);
        pv_wa = head;
      end
      default: rd_addr = s;
    endcase
  end

  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_wa] <= id_wd;
    if (ref_we) ref_mem[ref_wa] <= ref_wd;
    if (ab_we) ab_mem[ab_wa] <= ab_wd;
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    rd_id  <= id_mem[rd_addr];
    rd_ref <= ref_mem[rd_addr];
    rd_ab  <= ab_mem[rd_addr];
    rd_nx  <= nx_mem[rd_addr];
    rd_pv  <= pv_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      inq       <= '0;
      head      <= '0;
      tail      <= '0;
      qlen      <= '0;
      next_id   <= (ID_BITS+1)'(1);
      scan      <= '0;
      cmp_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.uop == UOP_FINISH) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (cmd.uop) inside
        UOP_LK_INIT, UOP_FF_INIT: begin
          scan  <= '0;
          cmp_v <= 1'b0;
        end
        UOP_LK_STEP: begin
          cmp_v <= (scan != SCAN_END);
          if (scan != SCAN_END) scan <= scan + SCAN_W'(1);
        end
        UOP_FF_STEP: begin
          if (scan != SCAN_END) scan <= scan + SCAN_W'(1);
        end
        UOP_CREATE: begin
          valid[s] <= 1'b1;
          inq[s]   <= 1'b0;
          next_id  <= next_id + (ID_BITS+1)'(1);
        end
        UOP_INVALIDATE_S: valid[s] <= 1'b0;
        UOP_UNLINK_U: begin
          inq[u] <= 1'b0;
          if (qlen != '0) qlen <= qlen - CNT_W'(1);
          if (qlen <= CNT_W'(1)) begin
            head <= '0;
            tail <= '0;
          end else begin
            if (u == head) head <= rd_nx;
            if (u == tail) tail <= rd_pv;
          end
        end
        UOP_PUSH2_U: begin
          if (qlen == '0) tail <= u;
          head   <= u;
          inq[u] <= 1'b1;
          qlen   <= qlen + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // working and output registers
  always_ff @(posedge clk) begin
    if (cmd.st_en) w_status <= cmd.st;
    case (cmd.uop)
      UOP_ACCEPT: begin
        op_r     <= opcode_t'(opcode);
        tid_r    <= thread_id;
        rel_r    <= release_former;
        w_status <= ST_OK;
        w_result <= '0;
        w_found  <= 1'b0;
        w_freed  <= 1'b0;
      end
      UOP_LK_STEP: begin
        if (scan != SCAN_END) cmp_idx <= scan_idx;
        if (lk_hit) begin
          s       <= cmp_idx;
          w_found <= 1'b1;
        end
      end
      UOP_FF_STEP: if (sts.ff_hit) s <= scan_idx;
      UOP_CREATE:       w_result <= next_id[ID_BITS-1:0];
      UOP_U_FROM_S:     u <= s;
      UOP_U_FROM_TAIL:  u <= tail;
      UOP_INVALIDATE_S: begin
        w_freed <= 1'b1;
        u       <= s;
      end
      UOP_REL_S:   if (sts.free_cond) w_freed <= 1'b1;
      UOP_RES_ID:  w_result <= rd_id;
      UOP_RES_TID: w_result <= tid_r;
      UOP_PICK_U:  w_result <= rd_id;
      UOP_FINISH: begin
        status      <= w_status;
        result_id   <= w_result;
        found       <= w_found;
        freed       <= w_freed;
        queue_count <= qlen;
      end
      default: ;
    endcase
  end

endmodule

// ----- tb/sv/tb_thread_table_round_robin_queue_unit.sv -----
// ----------------------------------------------------------------------------
// tb_thread_table_round_robin_queue_unit
// self-checking bench: directed scheduler scenarios, a capacity test, then random
// command streams; every result transaction is compared against an internal model
// of the thread table and run queue
// ----------------------------------------------------------------------------
module tb_thread_table_round_robin_queue_unit;
  import ttrrq_pkg::*;

  localparam int NSLOT   = 64;
  localparam int REF_TOP = 255;
  localparam int ID_TOP  = 65535;
  localparam longint CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  opcode;
  logic [15:0] thread_id;
  logic        release_former;
  logic        out_valid;
  logic        out_ready;
  status_t     status;
  logic [15:0] result_id;
  logic        found;
  logic        freed;
  logic [6:0]  queue_count;

  thread_table_round_robin_queue_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .thread_id(thread_id), .release_former(release_former),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .result_id(result_id), .found(found), .freed(freed),
    .queue_count(queue_count)
  );

  // expected result of one command
  typedef struct {
    status_t     st;
    logic [15:0] rid;
    logic        fnd;
    logic        fre;
    logic [6:0]  qlen;
  } sched_result_t;

  sched_result_t pending_results[$];

  // model of the table and run queue
  bit          tbl_valid[NSLOT];
  logic [15:0] tbl_id[NSLOT];
  int          tbl_refs[NSLOT];
  bit          tbl_dead[NSLOT];
  bit          tbl_queued[NSLOT];
  int          lnk_next[NSLOT];
  int          lnk_prev[NSLOT];
  int          q_head, q_tail, q_len;
  int          id_counter;

  int          errors = 0;
  int          sent_cnt = 0;
  int          recv_cnt = 0;
  longint      cycles = 0;
  bit          no_idle;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on a cycle counter
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int find_slot(logic [15:0] id);
    for (int i = 0; i < NSLOT; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void unlink(int s);
    int p, n;
    p = lnk_prev[s];
    n = lnk_next[s];
    if (s == q_head) q_head = n; else lnk_next[p] = n;
    if (s == q_tail) q_tail = p; else lnk_prev[n] = p;
    tbl_queued[s] = 0;
    if (q_len > 0) q_len--;
    if (q_len == 0) begin
      q_head = 0;
      q_tail = 0;
    end
  endfunction

  function automatic void push_front(int s);
    if (q_len == 0) begin
      q_tail = s;
      lnk_next[s] = s;
    end else begin
      lnk_next[s] = q_head;
      lnk_prev[q_head] = s;
    end
    lnk_prev[s] = s;
    q_head = s;
    tbl_queued[s] = 1;
    q_len++;
  endfunction

  function automatic int rotate_tail();
    int s;
    s = q_tail;
    unlink(s);
    push_front(s);
    return s;
  endfunction

  function automatic void drop_slot(int s);
    if (tbl_queued[s]) unlink(s);
    tbl_valid[s] = 0;
  endfunction

  // -1 count already zero, 1 slot freed, 0 decremented only
  function automatic int drop_ref(int s);
    if (tbl_refs[s] == 0) return -1;
    tbl_refs[s]--;
    if (tbl_refs[s] == 0 && tbl_dead[s]) begin
      drop_slot(s);
      return 1;
    end
    return 0;
  endfunction

  function automatic void reset_table();
    for (int i = 0; i < NSLOT; i++) begin
      tbl_valid[i] = 0;
      tbl_queued[i] = 0;
      tbl_id[i] = '0;
      tbl_refs[i] = 0;
      tbl_dead[i] = 0;
      lnk_next[i] = 0;
      lnk_prev[i] = 0;
    end
    q_head = 0;
    q_tail = 0;
    q_len = 0;
    id_counter = 1;
  endfunction

  // apply one command to the model and return what the unit should report
  function automatic sched_result_t run_command(logic [3:0] op, logic [15:0] tid, logic rel);
    sched_result_t res;
    int s, r, pick, cur;
    res.st = ST_OK;
    res.rid = '0;
    res.fnd = 0;
    res.fre = 0;
    s = -1;
    if (op >= OP_FIND && op <= OP_PICK && op != OP_DEQUEUE && op != OP_ROTATE) begin
      s = find_slot(tid);
      if (s < 0) res.st = ST_NOT_FOUND; else res.fnd = 1;
    end
    case (op)
      OP_CREATE: begin
        if (id_counter > ID_TOP) res.st = ST_NO_IDS;
        else begin
          r = -1;
          for (int i = NSLOT - 1; i >= 0; i--) if (!tbl_valid[i]) r = i;
          if (r < 0) res.st = ST_FULL;
          else begin
            tbl_valid[r] = 1;
            tbl_id[r] = id_counter[15:0];
            tbl_refs[r] = 0;
            tbl_dead[r] = 0;
            tbl_queued[r] = 0;
            res.rid = id_counter[15:0];
            id_counter++;
          end
        end
      end
      OP_FIND: ;
      OP_ACQUIRE: if (s >= 0 && tbl_refs[s] < REF_TOP) tbl_refs[s]++;
      OP_RELEASE: if (s >= 0) begin
        r = drop_ref(s);
        if (r < 0) res.st = ST_BAD_STATE;
        else if (r > 0) res.fre = 1;
      end
      OP_REMOVE: if (s >= 0) begin
        tbl_dead[s] = 1;
        if (tbl_refs[s] == 0) begin
          drop_slot(s);
          res.fre = 1;
        end
      end
      OP_ENQUEUE: if (s >= 0) begin
        if (tbl_queued[s]) res.st = ST_BAD_STATE; else push_front(s);
      end
      OP_UNQUEUE: if (s >= 0) begin
        if (!tbl_queued[s]) res.st = ST_BAD_STATE; else unlink(s);
      end
      OP_DEQUEUE, OP_ROTATE: begin
        if (q_len == 0) res.st = ST_EMPTY;
        else if (op == OP_DEQUEUE) begin
          r = q_tail;
          unlink(r);
          res.rid = tbl_id[r];
        end else res.rid = tbl_id[rotate_tail()];
      end
      OP_PICK: if (s >= 0) begin
        cur = s;
        if (q_len == 0) begin
          res.st = ST_EMPTY;
          res.rid = tid;
        end else if (tbl_queued[cur] && q_len == 1) res.rid = tid;
        else begin
          pick = rotate_tail();
          if (pick == cur) pick = rotate_tail();
          if (tbl_refs[pick] < REF_TOP) tbl_refs[pick]++;
          res.rid = tbl_id[pick];
          if (rel) begin
            r = drop_ref(cur);
            if (r < 0) res.st = ST_BAD_STATE;
            else if (r > 0) res.fre = 1;
          end
        end
      end
      default: res.st = ST_BAD_STATE;
    endcase
    res.qlen = q_len[6:0];
    return res;
  endfunction

  // send one command; model updated at acceptance
  task automatic send_cmd(logic [3:0] op, logic [15:0] tid, logic rel);
    while (!no_idle && $urandom_range(99) < 21) @(negedge clk);
    in_valid = 1;
    opcode = op;
    thread_id = tid;
    release_former = rel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(run_command(op, tid, rel));
    sent_cnt++;
    @(negedge clk);
    in_valid = 0;
  endtask

  // result side: random stall and compare
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= no_idle || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    sched_result_t e;
    if (!rst && out_valid && out_ready) begin
      recv_cnt++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st) begin
          $error("status exp %0d got %0d", e.st, status); errors++;
        end
        if (result_id !== e.rid) begin
          $error("result_id exp %0d got %0d", e.rid, result_id); errors++;
        end
        if (found !== e.fnd) begin
          $error("found exp %0d got %0d", e.fnd, found); errors++;
        end
        if (freed !== e.fre) begin
          $error("freed exp %0d got %0d", e.fre, freed); errors++;
        end
        if (queue_count !== e.qlen) begin
          $error("queue_count exp %0d got %0d", e.qlen, queue_count); errors++;
        end
      end
    end
  end

  // pick an id: mostly live ones, sometimes stale or arbitrary
  function automatic logic [15:0] any_id();
    int k;
    k = $urandom_range(99);
    if (k < 75) begin
      for (int t = 0; t < 8; t++) begin
        int s = $urandom_range(NSLOT - 1);
        if (tbl_valid[s]) return tbl_id[s];
      end
    end
    if (k < 90 && id_counter > 1) return 16'($urandom_range(id_counter - 1, 1));
    return 16'($urandom_range(ID_TOP));
  endfunction

  task automatic test_directed();
    // empty queue and unknown threads
    send_cmd(OP_DEQUEUE, 0, 0);
    send_cmd(OP_ROTATE, 0, 0);
    send_cmd(OP_FIND, 16'hFFFF, 0);
    send_cmd(4'd10, 0, 0);
    send_cmd(4'd15, 16'hFFFF, 1);
    send_cmd(OP_CREATE, 0, 0);
    send_cmd(OP_CREATE, 0, 0);
    send_cmd(OP_CREATE, 0, 0);
    send_cmd(OP_PICK, 1, 0);
    send_cmd(OP_RELEASE, 1, 0);
    send_cmd(OP_ENQUEUE, 1, 0);
    send_cmd(OP_ENQUEUE, 1, 0);
    send_cmd(OP_PICK, 1, 1);
    send_cmd(OP_ENQUEUE, 2, 0);
    send_cmd(OP_ENQUEUE, 3, 0);
    send_cmd(OP_PICK, 1, 1);
    send_cmd(OP_ACQUIRE, 1, 0);
    send_cmd(OP_PICK, 1, 1);
    send_cmd(OP_ROTATE, 0, 0);
    send_cmd(OP_REMOVE, 2, 0);
    send_cmd(OP_REMOVE, 2, 0);
    send_cmd(OP_RELEASE, 2, 0);
    send_cmd(OP_UNQUEUE, 3, 0);
    send_cmd(OP_UNQUEUE, 3, 0);
    send_cmd(OP_DEQUEUE, 0, 0);
  endtask

  // fill the table, saturate a refcount, queue every thread and pick, then send remove for every live thread
  task automatic test_capacity();
    for (int i = 0; i < NSLOT + 2; i++) send_cmd(OP_CREATE, 0, 0);
    for (int i = 0; i < REF_TOP + 2; i++) send_cmd(OP_ACQUIRE, tbl_id[0], 0);
    for (int i = 0; i < NSLOT; i++) send_cmd(OP_ENQUEUE, tbl_id[i], 0);
    for (int i = 0; i < 4; i++) send_cmd(OP_PICK, tbl_id[i], i[0]);
    for (int i = 0; i < NSLOT; i++) if (tbl_valid[i]) send_cmd(OP_REMOVE, tbl_id[i], 0);
  endtask

  task automatic test_random(int n);
    int k;
    logic [3:0] op;
    for (int i = 0; i < n; i++) begin
      no_idle = (i >= n / 2 && i < n / 2 + 150);
      k = $urandom_range(99);
      if (k < 3) op = 4'($urandom_range(15, 10));
      else if (k < 18 && id_counter <= ID_TOP) op = OP_CREATE;
      else op = 4'($urandom_range(9, 1));
      send_cmd(op, any_id(), 1'($urandom_range(1)));
    end
    no_idle = 0;
  endtask

  initial begin
    no_idle = 0;
    reset_table();
    rst = 1;
    in_valid = 0;
    opcode = '0;
    thread_id = '0;
    release_former = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    test_directed();
    test_capacity();
    test_random(1050);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("ran %0d commands, %0d results: directed cases, full table, saturated",
             sent_cnt, recv_cnt);
    $display("refcounts and random scheduler traffic with and without stalls");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- thread_table_round_robin_queue_unit.f -----
rtl/core/ttrrq_pkg.sv
rtl/core/ttrrq_ctrl.sv
rtl/core/ttrrq_dp.sv
rtl/core/thread_table_round_robin_queue_unit.sv
tb/sv/tb_thread_table_round_robin_queue_unit.sv
